>>> rtl/pf_pkg.sv
// ============================================================================
// pf_pkg: shared types, constants and helpers for the Playfair encryptor
// Letter indexes run 0..25 (A..Z). Square cells run 0..24 (row*5 + col).
// ============================================================================
package pf_pkg;

    localparam int SQ_DIM   = 5;
    localparam int SQ_CELLS = 25;
    localparam int ALPHA    = 26;

    typedef logic [4:0] t_letter;
    typedef logic [4:0] t_cell;
    typedef logic [2:0] t_coord;

    localparam t_letter IDX_I = 5'd8;
    localparam t_letter IDX_J = 5'd9;
    localparam t_letter IDX_X = 5'd23;
    localparam t_letter LAST_LETTER = 5'd25;
    localparam t_cell   CELLS_FULL  = 5'd25;

    localparam logic [7:0] ASCII_UA = 8'd65;
    localparam logic [7:0] ASCII_UZ = 8'd90;
    localparam logic [7:0] ASCII_LA = 8'd97;
    localparam logic [7:0] ASCII_LZ = 8'd122;
    localparam logic [6:0] ASCII_A7 = 7'd65;

    typedef struct packed {
        logic    valid;
        t_letter idx;
    } t_fold;

    // Table write: one new square entry and its letter's position.
    typedef struct packed {
        logic    en;
        t_letter letter;
        t_cell   slot;
    } t_tbl_wr;

    // Table reads: two letter positions, or two square cells.
    typedef struct packed {
        logic    pos_en;
        t_letter letter_a;
        t_letter letter_b;
        logic    sq_en;
        t_cell   cell_a;
        t_cell   cell_b;
    } t_tbl_rd;

    // Fold a byte to a letter index, J onto I; non-letters are invalid.
    function automatic t_fold fold_char(input logic [7:0] code);
        t_fold f;
        f.valid = 1'b0;
        f.idx   = '0;
        if (code >= ASCII_UA && code <= ASCII_UZ) begin
            f.valid = 1'b1;
            f.idx   = 5'(code - ASCII_UA);
        end else if (code >= ASCII_LA && code <= ASCII_LZ) begin
            f.valid = 1'b1;
            f.idx   = 5'(code - ASCII_LA);
        end
        if (f.idx == IDX_J) begin
            f.idx = IDX_I;
        end
        return f;
    endfunction

    function automatic t_coord cell_row(input t_cell c);
        t_coord r;
        if (c >= 5'd20)      r = 3'd4;
        else if (c >= 5'd15) r = 3'd3;
        else if (c >= 5'd10) r = 3'd2;
        else if (c >= 5'd5)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    function automatic t_coord cell_col(input t_cell c);
        t_cell base;
        base = 5'({2'b00, cell_row(c)} * 5'(SQ_DIM));
        return 3'(c - base);
    endfunction

    function automatic t_coord step5(input t_coord v);
        return (v == 3'(SQ_DIM - 1)) ? 3'd0 : 3'(v + 3'd1);
    endfunction

    function automatic t_cell cell_of(input t_coord r, input t_coord c);
        return 5'({r, 2'b00} + {2'b00, r} + {2'b00, c});
    endfunction

endpackage

>>> rtl/playfair_encryptor.sv
// ============================================================================
// playfair_encryptor: Playfair cipher over a stream of ASCII characters
// Builds the 5x5 key square from keyword characters, then pairs and
// enciphers text letters, one ciphertext letter per output transaction.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  input   | in        | i_valid / o_stall  | i_action, i_char_code, i_is_last
//  output  | out       | o_valid / i_stall  | o_cipher_letter, o_last_of_run
//
// A keyword letter is written when accepted, if new; an ending keyword
// character adds a walk over the alphabet that fills the rest of the
// square, one letter per cycle through the shared table write.
// A text character that completes a pair is looked up by two registered
// table reads (position memory, then square memory) and delivered letter
// by letter; up to two pairs (four letters) follow from one character.
// o_stall is high whenever the block is busy with a transaction. Output
// stalls hold the current letter. Synchronous active-low reset clears the
// letter-used set, fill count and pending letter; table contents are left
// as they are and are rewritten by the next keyword.
// ============================================================================
module playfair_encryptor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [7:0] i_char_code,
    input  logic       i_is_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_cipher_letter,
    output logic       o_last_of_run
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FILL  = 3'd1;
    localparam logic [2:0] S_POS   = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_EMIT1 = 3'd4;
    localparam logic [2:0] S_EMIT2 = 3'd5;

    // Control state
    logic [2:0]            r_state,      n_state;
    logic [25:0]           r_used,       n_used;
    pf_pkg::t_cell         r_fill,       n_fill;
    pf_pkg::t_letter       r_pend,       n_pend;
    logic                  r_pend_valid, n_pend_valid;
    logic                  r_more,       n_more;
    pf_pkg::t_letter       r_walk,       n_walk;

    // Pair payload
    pf_pkg::t_letter       r_pa, n_pa;
    pf_pkg::t_letter       r_pb, n_pb;
    pf_pkg::t_letter       r_pa2, n_pa2;

    pf_pkg::t_tbl_wr       wr;
    pf_pkg::t_tbl_rd       rd;
    pf_pkg::t_cell         pos_a, pos_b;
    pf_pkg::t_letter       sq_a, sq_b;

    pf_pkg::t_fold         fold;
    logic                  accept;
    logic                  has1, has2, mid_valid;
    pf_pkg::t_letter       b1, mid_letter;
    pf_pkg::t_letter       place_letter;
    logic                  place_try;

    pf_pkg::t_coord        row_a, col_a, row_b, col_b;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign fold    = pf_pkg::fold_char(i_char_code);

    // Output side: letters come straight from the registered square reads
    assign o_valid         = (r_state == S_EMIT1) || (r_state == S_EMIT2);
    assign o_cipher_letter = pf_pkg::ASCII_A7 +
                             {2'b00, (r_state == S_EMIT2) ? sq_b : sq_a};
    assign o_last_of_run   = (r_state == S_EMIT2) && !r_more;

    // Text pairing: first pair from the held letter, second from padding
    always_comb begin
        has1       = fold.valid && r_pend_valid;
        b1         = (fold.idx == r_pend) ? pf_pkg::IDX_X : fold.idx;
        mid_valid  = r_pend_valid;
        mid_letter = r_pend;
        if (fold.valid) begin
            if (!r_pend_valid) begin
                mid_valid  = 1'b1;
                mid_letter = fold.idx;
            end else if (fold.idx != r_pend) begin
                mid_valid  = 1'b0;
            end
        end
        has2 = i_is_last && mid_valid;
    end

    // Square coordinates of the two looked-up letters
    always_comb begin
        row_a = pf_pkg::cell_row(pos_a);
        col_a = pf_pkg::cell_col(pos_a);
        row_b = pf_pkg::cell_row(pos_b);
        col_b = pf_pkg::cell_col(pos_b);
    end

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_fill       = r_fill;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_more       = r_more;
        n_walk       = r_walk;
        n_pa         = r_pa;
        n_pb         = r_pb;
        n_pa2        = r_pa2;

        place_try    = 1'b0;
        place_letter = fold.idx;

        rd.pos_en    = (r_state == S_POS);
        rd.letter_a  = r_pa;
        rd.letter_b  = r_pb;
        rd.sq_en     = (r_state == S_SQ);
        // Rectangle rule unless the two letters share a row or column
        if (row_a == row_b) begin
            rd.cell_a = pf_pkg::cell_of(row_a, pf_pkg::step5(col_a));
            rd.cell_b = pf_pkg::cell_of(row_b, pf_pkg::step5(col_b));
        end else if (col_a == col_b) begin
            rd.cell_a = pf_pkg::cell_of(pf_pkg::step5(row_a), col_a);
            rd.cell_b = pf_pkg::cell_of(pf_pkg::step5(row_b), col_b);
        end else begin
            rd.cell_a = pf_pkg::cell_of(row_a, col_b);
            rd.cell_b = pf_pkg::cell_of(row_b, col_a);
        end

        case (r_state)
            S_IDLE: begin
                if (accept && !i_action) begin
                    place_try    = fold.valid;
                    place_letter = fold.idx;
                    if (i_is_last) begin
                        n_walk  = '0;
                        n_state = S_FILL;
                    end
                end else if (accept) begin
                    n_pend       = mid_letter;
                    n_pend_valid = mid_valid && !i_is_last;
                    n_pa2        = mid_letter;
                    n_pb         = pf_pkg::IDX_X;
                    if (has1) begin
                        n_pa    = r_pend;
                        n_pb    = b1;
                        n_more  = has2;
                        n_state = S_POS;
                    end else if (has2) begin
                        n_pa    = mid_letter;
                        n_more  = 1'b0;
                        n_state = S_POS;
                    end
                end
            end
            S_FILL: begin
                place_try    = (r_walk != pf_pkg::IDX_J);
                place_letter = r_walk;
                if (r_walk == pf_pkg::LAST_LETTER) begin
                    n_state = S_IDLE;
                end else begin
                    n_walk = r_walk + 5'd1;
                end
            end
            S_POS: begin
                n_state = S_SQ;
            end
            S_SQ: begin
                n_state = S_EMIT1;
            end
            S_EMIT1: begin
                if (!i_stall) begin
                    n_state = S_EMIT2;
                end
            end
            S_EMIT2: begin
                if (!i_stall) begin
                    if (r_more) begin
                        // Advance to the padded pair
                        n_pa    = r_pa2;
                        n_pb    = pf_pkg::IDX_X;
                        n_more  = 1'b0;
                        n_state = S_POS;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Append a letter once, while the square still has room
        wr.en     = place_try && (r_fill != pf_pkg::CELLS_FULL) && !r_used[place_letter];
        wr.letter = place_letter;
        wr.slot   = r_fill;
        if (wr.en) begin
            n_used[place_letter] = 1'b1;
            n_fill               = r_fill + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_fill       <= '0;
            r_pend       <= '0;
            r_pend_valid <= 1'b0;
            r_more       <= 1'b0;
            r_walk       <= '0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_fill       <= n_fill;
            r_pend       <= n_pend;
            r_pend_valid <= n_pend_valid;
            r_more       <= n_more;
            r_walk       <= n_walk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa  <= n_pa;
        r_pb  <= n_pb;
        r_pa2 <= n_pa2;
    end

    pf_tables u_tables (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_rd    (rd),
        .o_pos_a (pos_a),
        .o_pos_b (pos_b),
        .o_sq_a  (sq_a),
        .o_sq_b  (sq_b)
    );

endmodule

>>> rtl/pf_tables.sv
// ============================================================================
// pf_tables: key square and letter position memories
// Two synchronous memories, one write port each, two registered reads each.
// ============================================================================
module pf_tables (
    input  logic             i_clk,
    input  pf_pkg::t_tbl_wr  i_wr,
    input  pf_pkg::t_tbl_rd  i_rd,
    output pf_pkg::t_cell    o_pos_a,
    output pf_pkg::t_cell    o_pos_b,
    output pf_pkg::t_letter  o_sq_a,
    output pf_pkg::t_letter  o_sq_b
);

    pf_pkg::t_letter m_square [pf_pkg::SQ_CELLS];
    pf_pkg::t_cell   m_pos    [pf_pkg::ALPHA];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            m_square[i_wr.slot] <= i_wr.letter;
            m_pos[i_wr.letter]  <= i_wr.slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.pos_en) begin
            o_pos_a <= m_pos[i_rd.letter_a];
            o_pos_b <= m_pos[i_rd.letter_b];
        end
        if (i_rd.sq_en) begin
            o_sq_a <= m_square[i_rd.cell_a];
            o_sq_b <= m_square[i_rd.cell_b];
        end
    end

endmodule
